// ===== rtl/core/rlkd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlkd_pkg: shared types and constants of the ladder keypad decoder
// Opcodes, status codes, configuration layout and reset values.
// ----------------------------------------------------------------------------
package rlkd_pkg;

  // defaults for the top level parameters
  localparam int QUEUE_SLOTS_DEF = 16;
  localparam int TIMER_WIDTH_DEF = 16;

  // keypad table entries searched per sample
  localparam int TABLE_ENTRIES = 8;

  // depth of the command queue between front and back
  localparam int CMD_DEPTH = 4;

  // configuration port layout
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration reset values
  localparam logic [3:0]  RST_ENTRY_COUNT  = 4'd6;
  localparam logic [63:0] RST_LEVEL_TABLE  = 64'h0000_2A55_7FAA_D5E8;
  localparam logic [63:0] RST_CODE_TABLE   = 64'h0000_0605_0403_0201;
  localparam logic [7:0]  RST_MATCH_MARGIN = 8'd10;
  localparam logic [15:0] RST_HOLD_LIMIT   = 16'd200;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_NO_CODE  = 3'd2,
    ST_TOO_SOON = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_COUNT  = 3'd0,
    CFG_LEVEL_TABLE  = 3'd1,
    CFG_CODE_TABLE   = 3'd2,
    CFG_MATCH_MARGIN = 3'd3,
    CFG_HOLD_LIMIT   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  entry_count;
    logic [63:0] level_table;
    logic [63:0] code_table;
    logic [7:0]  match_margin;
    logic [15:0] hold_limit;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e        op;
    logic       rejected;
    logic [7:0] code;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

// ===== rtl/core/resistor_ladder_key_decoder_fifo_top.sv =====
// ----------------------------------------------------------------------------
// resistor_ladder_key_decoder_fifo_top: ladder keypad decoder with key ring
// Configuration registers, classifier, command queue and executor.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_ready_o) takes one opcode per transfer:
//   a sample, a millisecond tick, a pop or a clear of the key ring. The output
//   channel (out_valid_o / out_ready_i) returns exactly one result per input
//   transfer, in order: key_valid_o, key_code_o and sample_status_o.
//   Configuration writes go through cfg_valid_i / cfg_index_i / cfg_data_i,
//   always ready, and are expected only while the block is idle.
//   Each input transfer enters the command queue, and its result is registered
//   when the executor takes it from there. Throughput is one item per cycle
//   while the receiver takes results: the classifier compares all table
//   entries in parallel and the executor finishes each command as it pops it,
//   the key ring being a RAM with one write and one registered read port.
//   When the receiver stalls, the result register holds, the executor stops,
//   and the command queue takes up to 4 more items before in_ready_o drops.
//   Reset loads the default key table, disarms the hold timer and empties the
//   ring; the ring storage itself needs no clearing pass.
// ----------------------------------------------------------------------------
module resistor_ladder_key_decoder_fifo_top #(
  parameter int QUEUE_SLOTS = rlkd_pkg::QUEUE_SLOTS_DEF,
  parameter int TIMER_WIDTH = rlkd_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      opcode_i,
  input  logic [7:0]                      sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            key_valid_o,
  output logic [7:0]                      key_code_o,
  output logic [2:0]                      sample_status_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rlkd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rlkd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rlkd_pkg::cfg_t         cfg_q;
  rlkd_pkg::cmd_t         front_cmd;
  rlkd_pkg::cmd_t         back_cmd;
  rlkd_pkg::fifo_status_t fifo_status;
  logic                   push;
  logic                   pop;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_count  <= rlkd_pkg::RST_ENTRY_COUNT;
      cfg_q.level_table  <= rlkd_pkg::RST_LEVEL_TABLE;
      cfg_q.code_table   <= rlkd_pkg::RST_CODE_TABLE;
      cfg_q.match_margin <= rlkd_pkg::RST_MATCH_MARGIN;
      cfg_q.hold_limit   <= rlkd_pkg::RST_HOLD_LIMIT;
    end else if (cfg_valid_i) begin
      case (rlkd_pkg::cfg_idx_e'(cfg_index_i))
        rlkd_pkg::CFG_ENTRY_COUNT:  cfg_q.entry_count  <= cfg_data_i[3:0];
        rlkd_pkg::CFG_LEVEL_TABLE:  cfg_q.level_table  <= cfg_data_i;
        rlkd_pkg::CFG_CODE_TABLE:   cfg_q.code_table   <= cfg_data_i;
        rlkd_pkg::CFG_MATCH_MARGIN: cfg_q.match_margin <= cfg_data_i[7:0];
        rlkd_pkg::CFG_HOLD_LIMIT:   cfg_q.hold_limit   <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // classifier
  rlkd_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .sample_i    (sample_i),
    .cfg_i       (cfg_q),
    .fifo_full_i (fifo_status.full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  // command queue
  rlkd_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (back_cmd),
    .status_o (fifo_status)
  );

  // executor
  rlkd_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .hold_limit_i    (cfg_q.hold_limit),
    .cmd_valid_i     (!fifo_status.empty),
    .cmd_i           (back_cmd),
    .cmd_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .key_valid_o     (key_valid_o),
    .key_code_o      (key_code_o),
    .sample_status_o (sample_status_o)
  );

  // a full queue blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_status.full |-> !in_ready_o)
    else $error("input ready while command queue full");

  // queue never reports full and empty together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_status.full && fifo_status.empty))
    else $error("command queue full and empty at once");

  // a popped key never carries a sample status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_valid_o) |-> (sample_status_o == rlkd_pkg::ST_NONE))
    else $error("pop result with sample status");

  // the executor only runs with a queued command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("command taken from empty queue");

endmodule

// ===== rtl/core/rlkd_ram.sv =====
// ----------------------------------------------------------------------------
// rlkd_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rlkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rlkd_front.sv =====
// ----------------------------------------------------------------------------
// rlkd_front: input classifier
// Maps a sample onto the key table and flags codes beyond the entry count.
// ----------------------------------------------------------------------------
module rlkd_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           opcode_i,
  input  logic [7:0]           sample_i,
  input  rlkd_pkg::cfg_t       cfg_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output rlkd_pkg::cmd_t       cmd_o
);

  logic       hit;
  logic [7:0] mapped;

  // first table entry whose window covers the sample
  always_comb begin
    logic [7:0] lvl;
    logic [8:0] upper;
    logic [8:0] reach;
    logic       in_win;
    hit    = 1'b0;
    mapped = sample_i;
    for (int i = 0; i < rlkd_pkg::TABLE_ENTRIES; i++) begin
      lvl    = cfg_i.level_table[8*i +: 8];
      reach  = {1'b0, sample_i} + {1'b0, cfg_i.match_margin};
      upper  = {1'b0, lvl} + {1'b0, cfg_i.match_margin};
      in_win = (reach >= {1'b0, lvl}) && ({1'b0, sample_i} <= upper);
      if (!hit && (4'(i) < cfg_i.entry_count) && in_win) begin
        hit    = 1'b1;
        mapped = cfg_i.code_table[8*i +: 8];
      end
    end
  end

  // build the command for the back part
  always_comb begin
    cmd_o.op       = rlkd_pkg::op_e'(opcode_i);
    cmd_o.rejected = 1'b0;
    cmd_o.code     = 8'd0;
    if (cmd_o.op == rlkd_pkg::OP_SAMPLE) begin
      cmd_o.code     = mapped;
      cmd_o.rejected = mapped > {4'd0, cfg_i.entry_count};
    end
  end

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

endmodule

// ===== rtl/core/rlkd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rlkd_cmd_fifo: command queue between front and back
// Small register based queue of classified commands.
// ----------------------------------------------------------------------------
module rlkd_cmd_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  rlkd_pkg::cmd_t             cmd_i,
  input  logic                       pop_i,
  output rlkd_pkg::cmd_t             cmd_o,
  output rlkd_pkg::fifo_status_t     status_o
);

  localparam int PTR_W = $clog2(rlkd_pkg::CMD_DEPTH);
  localparam int CNT_W = $clog2(rlkd_pkg::CMD_DEPTH + 1);

  rlkd_pkg::cmd_t   slot_q [rlkd_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(rlkd_pkg::CMD_DEPTH));
  assign cmd_o          = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/core/rlkd_back.sv =====
// ----------------------------------------------------------------------------
// rlkd_back: command executor
// Runs the hold timer and the key ring, registers one result per command.
// ----------------------------------------------------------------------------
module rlkd_back #(
  parameter int QUEUE_SLOTS = rlkd_pkg::QUEUE_SLOTS_DEF,
  parameter int TIMER_WIDTH = rlkd_pkg::TIMER_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    hold_limit_i,
  input  logic           cmd_valid_i,
  input  rlkd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           key_valid_o,
  output logic [7:0]     key_code_o,
  output logic [2:0]     sample_status_o
);

  localparam int IDX_W = $clog2(QUEUE_SLOTS);
  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  logic                   armed_q, armed_d;
  logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [IDX_W-1:0]       rd_q, rd_d;
  logic [IDX_W-1:0]       wr_q, wr_d;
  logic                   out_valid_q, out_valid_d;
  logic                   key_hit_q, key_hit_d;
  rlkd_pkg::status_e      status_q, status_d;

  logic             fire;
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] wr_next;
  logic [IDX_W-1:0] rd_next;
  logic [7:0]       ram_rdata;
  logic             too_soon;

  assign fire      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = fire;
  assign wr_next   = next_idx(wr_q);
  assign rd_next   = next_idx(rd_q);
  assign too_soon  = CMP_W'(elapsed_q) < CMP_W'(hold_limit_i);

  // execute one command
  always_comb begin
    armed_d   = armed_q;
    elapsed_d = elapsed_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    key_hit_d = 1'b0;
    status_d  = rlkd_pkg::ST_NONE;
    if (fire) begin
      case (cmd_i.op)
        rlkd_pkg::OP_SAMPLE: begin
          if (cmd_i.rejected) begin
            status_d = rlkd_pkg::ST_NO_CODE;
          end else if (armed_q && too_soon) begin
            status_d = rlkd_pkg::ST_TOO_SOON;
          end else begin
            // arm on a fresh press, disarm once the hold has passed
            if (armed_q) begin
              armed_d = 1'b0;
            end else begin
              armed_d   = 1'b1;
              elapsed_d = '0;
            end
            if (wr_next == rd_q) begin
              status_d = rlkd_pkg::ST_FULL;
            end else begin
              wr_d     = wr_next;
              ram_we   = 1'b1;
              status_d = rlkd_pkg::ST_QUEUED;
            end
          end
        end
        rlkd_pkg::OP_TICK: begin
          if (armed_q && !(&elapsed_q)) begin
            elapsed_d = elapsed_q + 1'b1;
          end
        end
        rlkd_pkg::OP_POP: begin
          if (rd_q != wr_q) begin
            rd_d      = rd_next;
            ram_re    = 1'b1;
            key_hit_d = 1'b1;
          end
        end
        rlkd_pkg::OP_CLEAR: begin
          rd_d = LAST_IDX;
          wr_d = LAST_IDX;
        end
        default: begin
          status_d = rlkd_pkg::ST_NONE;
        end
      endcase
    end
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      elapsed_q   <= '0;
      rd_q        <= LAST_IDX;
      wr_q        <= LAST_IDX;
      out_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      elapsed_q   <= elapsed_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      key_hit_q <= key_hit_d;
      status_q  <= status_d;
    end
  end

  // key ring storage
  rlkd_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_next),
    .wdata_i (cmd_i.code),
    .re_i    (ram_re),
    .raddr_i (rd_next),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign key_valid_o     = key_hit_q;
  assign key_code_o      = key_hit_q ? ram_rdata : 8'd0;
  assign sample_status_o = status_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ladder keypad decoder with key ring
// Drives samples, ticks, pops and clears through the valid/ready input,
// predicts every result in a local copy of the decoder, hold timer and ring,
// and checks each result transfer in order under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import rlkd_pkg::*;

  localparam int SLOTS          = QUEUE_SLOTS_DEF;
  localparam int TICK_BITS      = TIMER_WIDTH_DEF;
  // receiver hold-off long enough to fill the command queue and stall input
  localparam int STALL_CYCLES   = 400;
  // slack for the pipeline to empty before config writes and the end
  localparam int DRAIN_CYCLES   = 8;
  // longest quiet stretch in a good run follows the receiver hold-off; the limit sits well above it
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_code;
    status_e    status;
  } key_result_t;

  // dut ports
  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  op_e                   opcode_i    = OP_SAMPLE;
  logic [7:0]            sample_i    = 8'h00;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  key_valid_o;
  logic [7:0]            key_code_o;
  logic [2:0]            sample_status_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // register shadow
  logic [3:0]  cfg_count  = RST_ENTRY_COUNT;
  logic [63:0] cfg_levels = RST_LEVEL_TABLE;
  logic [63:0] cfg_codes  = RST_CODE_TABLE;
  logic [7:0]  cfg_margin = RST_MATCH_MARGIN;
  logic [15:0] cfg_hold   = RST_HOLD_LIMIT;

  // predicted decoder state
  logic                 hold_armed = 1'b0;
  logic [TICK_BITS-1:0] hold_ticks = '0;
  logic [7:0]           ring_keys [SLOTS];
  int                   ring_rd = SLOTS - 1;
  int                   ring_wr = SLOTS - 1;

  key_result_t key_results_due [$];
  key_result_t due_key;

  int send_idle_pct = 35;
  int recv_idle_pct = 60;
  int stall_request = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int keys_popped   = 0;
  int status_hits [5];
  int phase_no      = 0;

  resistor_ladder_key_decoder_fifo_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .key_valid_o     (key_valid_o),
    .key_code_o      (key_code_o),
    .sample_status_o (sample_status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // decoder prediction
  // ---------------------------------------------------------------------------

  // first entry whose window holds the sample, else the raw sample
  function automatic logic [7:0] ladder_code(logic [7:0] smp);
    int n;
    int lvl;
    int m;
    n = (cfg_count < TABLE_ENTRIES) ? cfg_count : TABLE_ENTRIES;
    m = cfg_margin;
    for (int i = 0; i < n; i++) begin
      lvl = cfg_levels[8*i +: 8];
      if (int'(smp) >= lvl - m && int'(smp) <= lvl + m) return cfg_codes[8*i +: 8];
    end
    return smp;
  endfunction

  // code check, hold timer arm/reject/clear, then ring push
  function automatic status_e press_status(logic [7:0] smp);
    logic [7:0] code;
    int nxt;
    code = ladder_code(smp);
    if (code > cfg_count) return ST_NO_CODE;
    if (hold_armed) begin
      if (hold_ticks < cfg_hold) return ST_TOO_SOON;
      hold_armed = 1'b0;
    end else begin
      hold_armed = 1'b1;
      hold_ticks = '0;
    end
    nxt = (ring_wr + 1) % SLOTS;
    if (nxt == ring_rd) return ST_FULL;
    ring_wr = nxt;
    ring_keys[ring_wr] = code;
    return ST_QUEUED;
  endfunction

  function automatic key_result_t decode_item(op_e op, logic [7:0] smp);
    key_result_t r;
    r = '{key_valid: 1'b0, key_code: 8'h00, status: ST_NONE};
    case (op)
      OP_SAMPLE: r.status = press_status(smp);
      OP_TICK: begin
        if (hold_armed && hold_ticks != '1) hold_ticks = hold_ticks + 1'b1;
      end
      OP_POP: begin
        if (ring_rd != ring_wr) begin
          ring_rd = (ring_rd + 1) % SLOTS;
          r.key_valid = 1'b1;
          r.key_code = ring_keys[ring_rd];
        end
      end
      default: begin
        ring_rd = SLOTS - 1;
        ring_wr = SLOTS - 1;
      end
    endcase
    return r;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("tb_top: mismatch at %0t: %s", $realtime, what);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input transfer; valid stays high afterwards unless the next item idles
  task automatic send_item(op_e op, logic [7:0] smp);
    key_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    sample_i   <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    r = decode_item(op, smp);
    key_results_due.push_back(r);
    items_sent++;
    status_hits[r.status]++;
    if (r.key_valid) keys_popped++;
  endtask

  // sender pause until every result is back, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (key_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ENTRY_COUNT:  cfg_count  = value[3:0];
      CFG_LEVEL_TABLE:  cfg_levels = value;
      CFG_CODE_TABLE:   cfg_codes  = value;
      CFG_MATCH_MARGIN: cfg_margin = value[7:0];
      CFG_HOLD_LIMIT:   cfg_hold   = value[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [3:0] count, logic [63:0] levels, logic [63:0] codes,
                               logic [7:0] margin, logic [15:0] hold);
    settle();
    write_reg(CFG_ENTRY_COUNT, 64'(count));
    write_reg(CFG_LEVEL_TABLE, levels);
    write_reg(CFG_CODE_TABLE, codes);
    write_reg(CFG_MATCH_MARGIN, 64'(margin));
    write_reg(CFG_HOLD_LIMIT, 64'(hold));
  endtask

  task automatic random_setting();
    logic [3:0]  count;
    logic [63:0] levels;
    logic [63:0] codes;
    logic [7:0]  margin;
    logic [15:0] hold;
    count  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
    levels = {$urandom, $urandom};
    for (int i = 0; i < 8; i++)
      codes[8*i +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(9));
    margin = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20));
    hold   = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(12));
    apply_setting(count, levels, codes, margin, hold);
  endtask

  // samples on, just outside or inside a window edge, and some raw noise
  function automatic logic [7:0] pick_sample();
    int n;
    int lvl;
    int m;
    int v;
    n = (cfg_count < TABLE_ENTRIES) ? cfg_count : TABLE_ENTRIES;
    if (n == 0 || $urandom_range(9) >= 6)
      return ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
    lvl = cfg_levels[8*$urandom_range(n - 1) +: 8];
    m = cfg_margin;
    case ($urandom_range(3))
      0: v = lvl - m;
      1: v = lvl + m;
      2: v = ($urandom_range(1) == 0) ? lvl - m - 1 : lvl + m + 1;
      default: v = lvl - m + int'($urandom_range(2 * m));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // one random operation; ticks come in bursts so the hold timer can expire
  task automatic random_item();
    int pick;
    int burst;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_item(OP_SAMPLE, pick_sample());
    end else if (pick < 70) begin
      burst = $urandom_range(1, ((cfg_hold > 24) ? 24 : int'(cfg_hold)) + 3);
      repeat (burst) send_item(OP_TICK, 8'($urandom));
    end else if (pick < 93) begin
      send_item(OP_POP, 8'($urandom));
    end else begin
      send_item(OP_CLEAR, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver, result check and watchdog
  // ---------------------------------------------------------------------------

  // random ready, or a long hold-off when the stimulus asks for one
  always @(posedge clk_i) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (key_results_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing outstanding: valid %0b code %02h status %0d",
                                key_valid_o, key_code_o, sample_status_o));
      end else begin
        due_key = key_results_due.pop_front();
        if (key_valid_o !== due_key.key_valid || key_code_o !== due_key.key_code ||
            sample_status_o !== due_key.status)
          flag_mismatch($sformatf(
            "key_valid exp %0b got %0b, key_code exp %02h got %02h, status exp %0d got %0d",
            due_key.key_valid, key_valid_o, due_key.key_code, key_code_o,
            due_key.status, sample_status_o));
      end
    end
  end

  // cycles without any transfer on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset table: first two windows hit, raw small and large code, too soon, empty pop
  task automatic test_reset_table();
    send_item(OP_POP, 8'h00);
    send_item(OP_SAMPLE, 8'hE8);
    send_item(OP_SAMPLE, 8'hD5);
    send_item(OP_SAMPLE, 8'hFF);
    send_item(OP_SAMPLE, 8'h00);
    send_item(OP_SAMPLE, 8'hDF);
    send_item(OP_TICK, 8'hA5);
    send_item(OP_POP, 8'h5A);
    send_item(OP_POP, 8'h00);
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_POP, 8'h00);
  endtask

  // windows clipped at 0 and 255, first match wins, count above table size
  task automatic test_window_edges();
    apply_setting(4'd15, 64'hA0_60_C0_40_80_10_FF_00, 64'h0E_03_02_01_07_10_00_0F,
                  8'd10, 16'd2);
    send_item(OP_SAMPLE, 8'h00);
    send_item(OP_SAMPLE, 8'hF5);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_SAMPLE, 8'hF5);
    send_item(OP_SAMPLE, 8'h1A);
    send_item(OP_SAMPLE, 8'h09);
    send_item(OP_SAMPLE, 8'hAA);
    repeat (4) send_item(OP_POP, 8'h00);
    // no entries searched, widest margin, longest hold
    apply_setting(4'd0, cfg_levels, cfg_codes, 8'hFF, 16'hFFFF);
    send_item(OP_SAMPLE, 8'h00);
    send_item(OP_SAMPLE, 8'h01);
    send_item(OP_SAMPLE, 8'hFF);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_POP, 8'h00);
  endtask

  // fill the ring past its capacity, then drain it through the wrap point
  task automatic test_ring_full();
    apply_setting(4'd8, 64'hE0_C0_A0_80_60_40_20_00, 64'h07_06_05_04_03_02_01_00,
                  8'd0, 16'd0);
    send_item(OP_CLEAR, 8'h00);
    for (int i = 0; i < SLOTS; i++) send_item(OP_SAMPLE, 8'(32 * (i % 8)));
    send_item(OP_TICK, 8'h00);
    repeat (SLOTS) send_item(OP_POP, 8'h00);
    for (int i = 0; i < 6; i++) send_item(OP_SAMPLE, 8'(32 * i));
    repeat (3) send_item(OP_POP, 8'h00);
  endtask

  // hold timer rejects one tick short of the limit and accepts at the limit
  task automatic test_hold_expiry();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting(4'd6, RST_LEVEL_TABLE, RST_CODE_TABLE, 8'd0, 16'd40);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_SAMPLE, 8'hE8);
    repeat (39) send_item(OP_TICK, 8'($urandom));
    send_item(OP_SAMPLE, 8'hD5);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SAMPLE, 8'hD5);
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);
    settle();
  endtask

  // receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting(4'd6, RST_LEVEL_TABLE, RST_CODE_TABLE, 8'd12, 16'd3);
    stall_request = STALL_CYCLES;
    repeat (40) random_item();
    settle();
    repeat (20) random_item();
    settle();
  endtask

  // random traffic over several register settings, extremes first
  task automatic test_random(int n_items, int send_pct, int recv_pct);
    int target;
    int chunk;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = items_sent + n_items;
    case (phase_no)
      0: apply_setting(4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'hFF, 16'd0);
      1: apply_setting(4'd15, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'hFFFF);
      default: apply_setting(4'd0, {$urandom, $urandom}, {$urandom, $urandom}, 8'd0, 16'd1);
    endcase
    phase_no++;
    while (items_sent < target) begin
      chunk = items_sent + 100;
      while (items_sent < chunk && items_sent < target) random_item();
      if (items_sent < target) random_setting();
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_table();
    test_window_edges();
    test_ring_full();
    test_random(500, 35, 60);
    test_random(400, 60, 35);
    test_random(300, 0, 0);
    test_backpressure();
    test_hold_expiry();

    settle();
    if (key_results_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", key_results_due.size()));
    $display("tb_top: %0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("tb_top: presses queued %0d, full %0d, too soon %0d, no code %0d; keys popped %0d",
             status_hits[ST_QUEUED], status_hits[ST_FULL], status_hits[ST_TOO_SOON],
             status_hits[ST_NO_CODE], keys_popped);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rlkd_pkg.sv
rtl/core/rlkd_ram.sv
rtl/core/rlkd_front.sv
rtl/core/rlkd_cmd_fifo.sv
rtl/core/rlkd_back.sv
rtl/core/resistor_ladder_key_decoder_fifo_top.sv
bench/tb_top.sv
